// ===== hw/rtl/pfr_pkg.sv =====
// Types, codes and helpers shared by the position frame receiver modules.
`default_nettype none

package pfr_pkg;

  // Number of payload bytes kept for decoding (four 32-bit words).
  localparam int unsigned StoreDepth = 16;
  // Hard ceiling on the frame length, independent of the length registers.
  localparam logic [7:0] MaxPayload = 8'd64;

  typedef enum logic [3:0] {
    PH_START1,
    PH_START2,
    PH_ID,
    PH_LEN,
    PH_PAYLOAD,
    PH_CHECK1,
    PH_CHECK2,
    PH_END1,
    PH_END2
  } phase_e;

  typedef enum logic [2:0] {
    REG_START_FIRST,
    REG_START_SECOND,
    REG_END_FIRST,
    REG_END_SECOND,
    REG_ACCEPT_ID,
    REG_MIN_LEN,
    REG_MAX_LEN
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] start_first;
    logic [7:0] start_second;
    logic [7:0] end_first;
    logic [7:0] end_second;
    logic [7:0] accept_id;
    logic [6:0] min_len;
    logic [6:0] max_len;
  } cfg_t;

  // Per-byte outcome handed to the output register.
  typedef struct packed {
    logic       done;
    logic [7:0] id;
  } res_t;

  function automatic logic len_ok(logic [7:0] len, cfg_t cfg);
    return (len >= {1'b0, cfg.min_len}) && (len <= {1'b0, cfg.max_len}) &&
           (len <= MaxPayload) && (len[1:0] == 2'b00);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pfr_cfg.sv =====
// Configuration register file of the position frame receiver.
`default_nettype none

module pfr_cfg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_en_i,
  input  wire logic [2:0]    wr_index_i,
  input  wire logic [7:0]    wr_data_i,
  output pfr_pkg::cfg_t      cfg_o
);

  pfr_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (pfr_pkg::reg_idx_e'(wr_index_i))
        pfr_pkg::REG_START_FIRST:  cfg_d.start_first  = wr_data_i;
        pfr_pkg::REG_START_SECOND: cfg_d.start_second = wr_data_i;
        pfr_pkg::REG_END_FIRST:    cfg_d.end_first    = wr_data_i;
        pfr_pkg::REG_END_SECOND:   cfg_d.end_second   = wr_data_i;
        pfr_pkg::REG_ACCEPT_ID:    cfg_d.accept_id    = wr_data_i;
        pfr_pkg::REG_MIN_LEN:      cfg_d.min_len      = wr_data_i[6:0];
        pfr_pkg::REG_MAX_LEN:      cfg_d.max_len      = wr_data_i[6:0];
        default:                   cfg_d = cfg_q;   // unmapped index
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_first  <= 8'd0;
      cfg_q.start_second <= 8'd0;
      cfg_q.end_first    <= 8'd0;
      cfg_q.end_second   <= 8'd0;
      cfg_q.accept_id    <= 8'd0;
      cfg_q.min_len      <= 7'd16;
      cfg_q.max_len      <= 7'd16;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pfr_frame.sv =====
// Frame state machine, payload store and latched position words.
`default_nettype none

module pfr_frame (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          byte_en_i,
  input  wire logic [7:0]    rx_byte_i,
  input  wire pfr_pkg::cfg_t cfg_i,
  output pfr_pkg::res_t      res_o,
  output logic [6:0]         latched_len_o,
  output logic [31:0]        accept_cnt_o,
  output logic [31:0]        word_o [4]
);

  pfr_pkg::phase_e phase_q, phase_d;
  logic [7:0]  id_q, id_d;
  logic [6:0]  len_q, len_d;
  logic [6:0]  pos_q, pos_d;
  logic [7:0]  store_q [pfr_pkg::StoreDepth];
  logic [6:0]  latched_len_q;
  logic [31:0] accept_cnt_q;
  logic [31:0] word_q [4];
  logic [6:0]  pos_inc;
  logic        restart;
  logic        store_we;
  logic        latch;

  assign pos_inc = pos_q + 7'd1;

  always_comb begin
    phase_d  = phase_q;
    id_d     = id_q;
    len_d    = len_q;
    pos_d    = pos_q;
    restart  = 1'b0;
    store_we = 1'b0;
    latch    = 1'b0;
    case (phase_q)
      pfr_pkg::PH_START1: begin
        if (rx_byte_i == cfg_i.start_first) phase_d = pfr_pkg::PH_START2;
      end
      pfr_pkg::PH_START2: begin
        // a repeated first start byte keeps us waiting here
        if (rx_byte_i == cfg_i.start_second) phase_d = pfr_pkg::PH_ID;
        else if (rx_byte_i != cfg_i.start_first) restart = 1'b1;
      end
      pfr_pkg::PH_ID: begin
        id_d    = rx_byte_i;
        phase_d = pfr_pkg::PH_LEN;
      end
      pfr_pkg::PH_LEN: begin
        if (!pfr_pkg::len_ok(rx_byte_i, cfg_i)) begin
          restart = 1'b1;
        end else begin
          len_d   = rx_byte_i[6:0];
          pos_d   = 7'd0;
          phase_d = (rx_byte_i == 8'd0) ? pfr_pkg::PH_CHECK1 : pfr_pkg::PH_PAYLOAD;
        end
      end
      pfr_pkg::PH_PAYLOAD: begin
        store_we = (pos_q[6:4] == 3'd0);
        pos_d    = pos_inc;
        if (pos_inc >= len_q) phase_d = pfr_pkg::PH_CHECK1;
      end
      pfr_pkg::PH_CHECK1: phase_d = pfr_pkg::PH_CHECK2;
      pfr_pkg::PH_CHECK2: phase_d = pfr_pkg::PH_END1;
      pfr_pkg::PH_END1: begin
        if (rx_byte_i == cfg_i.end_first) phase_d = pfr_pkg::PH_END2;
        else restart = 1'b1;
      end
      pfr_pkg::PH_END2: begin
        // length is checked again against the current registers
        latch   = (rx_byte_i == cfg_i.end_second) && (id_q == cfg_i.accept_id) &&
                  pfr_pkg::len_ok({1'b0, len_q}, cfg_i);
        restart = 1'b1;
      end
      default: restart = 1'b1;
    endcase
    if (restart) begin
      phase_d = pfr_pkg::PH_START1;
      id_d    = 8'd0;
      len_d   = 7'd0;
      pos_d   = 7'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pfr_pkg::PH_START1;
      id_q    <= 8'd0;
      len_q   <= 7'd0;
      pos_q   <= 7'd0;
    end else if (byte_en_i) begin
      phase_q <= phase_d;
      id_q    <= id_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pfr_pkg::StoreDepth; i++) store_q[i] <= 8'd0;
    end else if (byte_en_i) begin
      if (restart) begin
        for (int i = 0; i < pfr_pkg::StoreDepth; i++) store_q[i] <= 8'd0;
      end else if (store_we) begin
        store_q[pos_q[3:0]] <= rx_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latched_len_q <= 7'd0;
      accept_cnt_q  <= 32'd0;
      for (int k = 0; k < 4; k++) word_q[k] <= 32'd0;
    end else if (byte_en_i && latch) begin
      latched_len_q <= len_q;
      accept_cnt_q  <= accept_cnt_q + 32'd1;
      for (int k = 0; k < 4; k++) begin
        word_q[k] <= {store_q[4*k+3], store_q[4*k+2], store_q[4*k+1], store_q[4*k]};
      end
    end
  end

  assign res_o.done    = latch;
  assign res_o.id      = latch ? id_q : 8'd0;
  assign latched_len_o = latched_len_q;
  assign accept_cnt_o  = accept_cnt_q;
  assign word_o        = word_q;

endmodule

`default_nettype wire

// ===== hw/rtl/position_frame_receiver.sv =====
// Top level of the position frame receiver: config port, frame engine, output register.
//
// Usage notes
// - Input channel: one received byte per transaction on rx_byte_i, taken at an
//   edge where in_valid_i is high and in_stall_o is low.
// - Output channel: exactly one result transaction per input byte, in order,
//   taken where out_valid_o is high and out_stall_i is low. frame_done_o and
//   decoded_id_o belong to that byte; the length, counter and four raw float
//   words are the values latched by the last accepted frame.
// - Latency: the result of a byte is presented on the cycle after its
//   acceptance. Throughput: one byte per cycle while in_stall_o is low; the
//   whole frame step is a single pass of state logic between the input port
//   and the result registers.
// - Stall: while a result waits and out_stall_i is high, in_stall_o is raised;
//   a new byte is taken in the same cycle the waiting result leaves.
// - Config: seven byte-wide registers written through cfg_valid_i/cfg_ready_o,
//   always ready; write only while the block is idle. Lengths use bits [6:0].
// - Reset: waits for the first start byte, store and latched words zero,
//   counter zero, min/max length 16, all marker and id registers zero.
`default_nettype none

module position_frame_receiver (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  // byte input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             frame_done_o,
  output logic [7:0]       decoded_id_o,
  output logic [6:0]       last_payload_len_o,
  output logic [31:0]      frames_accepted_o,
  output logic [31:0]      x_bits_o,
  output logic [31:0]      y_bits_o,
  output logic [31:0]      yaw_bits_o,
  output logic [31:0]      yaw_rate_bits_o
);

  pfr_pkg::cfg_t cfg;
  pfr_pkg::res_t res;
  pfr_pkg::res_t res_q;
  logic          out_valid_q;
  logic          in_accept;
  logic          out_accept;
  logic [31:0]   words [4];

  assign cfg_ready_o = 1'b1;

  pfr_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Only a waiting result that cannot leave holds off the next byte.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_accept = out_valid_q && !out_stall_i;

  // Frame state and latched words only advance on an accepted byte, so the
  // latched registers always match the result in the output register.
  pfr_frame u_frame (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_en_i     (in_accept),
    .rx_byte_i     (rx_byte_i),
    .cfg_i         (cfg),
    .res_o         (res),
    .latched_len_o (last_payload_len_o),
    .accept_cnt_o  (frames_accepted_o),
    .word_o        (words)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (in_accept) begin
        out_valid_q <= 1'b1;
        res_q       <= res;
      end else if (out_accept) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign frame_done_o    = res_q.done;
  assign decoded_id_o    = res_q.id;
  assign x_bits_o        = words[0];
  assign y_bits_o        = words[1];
  assign yaw_bits_o      = words[2];
  assign yaw_rate_bits_o = words[3];

`ifndef ASSERT_OFF
  // Counter steps by one exactly with a completed frame.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (frames_accepted_o == $past(frames_accepted_o) + 32'(frame_done_o)))
    else $error("frame counter does not follow frame_done");

  // No byte, no change to the counter.
  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_accept |=> $stable(frames_accepted_o))
    else $error("frame counter moved without an input transaction");

  // Id is reported only with a completed frame.
  a_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !frame_done_o) |-> (decoded_id_o == 8'd0))
    else $error("decoded id set without frame_done");

  // Back-pressure only ever comes from a waiting result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no pending result");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/position_frame_tracker_pkg.sv =====
// Expected-result tracker for the position frame receiver testbench.
`timescale 1ns / 1ps

package position_frame_tracker_pkg;

  import pfr_pkg::*;

  typedef struct packed {
    logic        done;
    logic [7:0]  id;
    logic [6:0]  len;
    logic [31:0] count;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] yaw;
    logic [31:0] yaw_rate;
  } frame_result_t;

  class position_frame_tracker;
    // register copy
    logic [7:0]  start_first, start_second, end_first, end_second, accept_id;
    logic [6:0]  min_len, max_len;
    // receiver state
    phase_e      rx_phase;
    logic [7:0]  held_id, held_len, byte_pos;
    logic [7:0]  store [StoreDepth];
    logic [31:0] accept_cnt;
    logic [31:0] words [4];
    logic [6:0]  latched_len;

    frame_result_t awaited_results[$];
    int unsigned   failures;

    function new();
      start_first  = '0;
      start_second = '0;
      end_first    = '0;
      end_second   = '0;
      accept_id    = '0;
      min_len      = 7'd16;
      max_len      = 7'd16;
      restart_frame();
      accept_cnt   = '0;
      foreach (words[k]) words[k] = '0;
      latched_len  = '0;
      failures     = 0;
    endfunction

    function void restart_frame();
      rx_phase = PH_START1;
      held_id  = '0;
      held_len = '0;
      byte_pos = '0;
      foreach (store[k]) store[k] = '0;
    endfunction

    function bit length_fits(logic [7:0] len);
      return (len >= {1'b0, min_len}) && (len <= {1'b0, max_len}) &&
             (len <= MaxPayload) && (len[1:0] == 2'b00);
    endfunction

    function void write_reg(logic [2:0] idx, logic [7:0] data);
      case (idx)
        REG_START_FIRST:  start_first  = data;
        REG_START_SECOND: start_second = data;
        REG_END_FIRST:    end_first    = data;
        REG_END_SECOND:   end_second   = data;
        REG_ACCEPT_ID:    accept_id    = data;
        REG_MIN_LEN:      min_len      = data[6:0];
        REG_MAX_LEN:      max_len      = data[6:0];
        default: ;
      endcase
    endfunction

    // Advance the receiver by one byte and queue the result it owes.
    function void take_byte(logic [7:0] b);
      frame_result_t r;
      r = '0;
      case (rx_phase)
        PH_START1: if (b == start_first) rx_phase = PH_START2;
        PH_START2: begin
          if (b == start_second) rx_phase = PH_ID;
          else if (b != start_first) restart_frame();
        end
        PH_ID: begin
          held_id  = b;
          rx_phase = PH_LEN;
        end
        PH_LEN: begin
          if (!length_fits(b)) begin
            restart_frame();
          end else begin
            held_len = b;
            byte_pos = '0;
            rx_phase = (b == 8'd0) ? PH_CHECK1 : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (byte_pos < StoreDepth) store[byte_pos[3:0]] = b;
          byte_pos = byte_pos + 8'd1;
          if (byte_pos >= held_len) rx_phase = PH_CHECK1;
        end
        PH_CHECK1: rx_phase = PH_CHECK2;
        PH_CHECK2: rx_phase = PH_END1;
        PH_END1: begin
          if (b == end_first) rx_phase = PH_END2;
          else restart_frame();
        end
        PH_END2: begin
          if (b == end_second && held_id == accept_id && length_fits(held_len)) begin
            for (int k = 0; k < 4; k++)
              words[k] = {store[4*k+3], store[4*k+2], store[4*k+1], store[4*k]};
            latched_len = held_len[6:0];
            accept_cnt  = accept_cnt + 32'd1;
            r.done      = 1'b1;
            r.id        = held_id;
          end
          restart_frame();
        end
        default: restart_frame();
      endcase
      r.len      = latched_len;
      r.count    = accept_cnt;
      r.x        = words[0];
      r.y        = words[1];
      r.yaw      = words[2];
      r.yaw_rate = words[3];
      awaited_results.push_back(r);
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t want;
      if (awaited_results.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected result %p", got);
        return;
      end
      want = awaited_results.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch done %0b/%0b id %h/%h len %0d/%0d count %0d/%0d",
                   want.done, got.done, want.id, got.id, want.len, got.len,
                   want.count, got.count);
          $display("  x %h/%h y %h/%h yaw %h/%h rate %h/%h",
                   want.x, got.x, want.y, got.y, want.yaw, got.yaw,
                   want.yaw_rate, got.yaw_rate);
        end
      end
    endfunction

    function int outstanding();
      return awaited_results.size();
    endfunction
  endclass

endpackage

// ===== tb/sv/tb_top.sv =====
// Top-level testbench for the position frame receiver.
`timescale 1ns / 1ps

module tb_top;

  import pfr_pkg::*;
  import position_frame_tracker_pkg::*;

  // index 7 is not a register; writes there must be ignored
  localparam logic [2:0] RegSpare   = 3'd7;
  localparam int unsigned CycleLimit = 200000;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [7:0]  cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  rx_byte_i   = '0;
  logic        out_stall_i = 1'b0;
  logic        cfg_ready_o;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        frame_done_o;
  logic [7:0]  decoded_id_o;
  logic [6:0]  last_payload_len_o;
  logic [31:0] frames_accepted_o;
  logic [31:0] x_bits_o, y_bits_o, yaw_bits_o, yaw_rate_bits_o;

  position_frame_tracker tracker;

  // Data last written to each register, kept so frames can be built to match.
  logic [7:0]  reg_val [7];
  // High during a stretch where neither side idles.
  bit          calm = 1'b0;
  int unsigned bytes_sent   = 0;
  int unsigned cycle_count  = 0;

  position_frame_receiver u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .rx_byte_i          (rx_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .frame_done_o       (frame_done_o),
    .decoded_id_o       (decoded_id_o),
    .last_payload_len_o (last_payload_len_o),
    .frames_accepted_o  (frames_accepted_o),
    .x_bits_o           (x_bits_o),
    .y_bits_o           (y_bits_o),
    .yaw_bits_o         (yaw_bits_o),
    .yaw_rate_bits_o    (yaw_rate_bits_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side: stalls roughly a quarter of the time, never in a calm stretch.
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 26);
  end

  // Every result transaction goes to the tracker. Signals are read in the
  // active region of the edge, so they still hold their pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      tracker.check_result(frame_result_t'({frame_done_o, decoded_id_o,
                                             last_payload_len_o, frames_accepted_o,
                                             x_bits_o, y_bits_o, yaw_bits_o,
                                             yaw_rate_bits_o}));
  end

  // Hard stop should the handshake hang.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // One byte transaction: optional idle gap, then hold the byte until taken.
  // The byte is handed to the tracker at the edge that accepts it.
  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 26) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    tracker.take_byte(b);
    bytes_sent++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    tracker.write_reg(idx, data);
  endtask

  // Rewrite every register once the result channel has drained. The receiver
  // may well be part way through a frame; that is intended. Length data gets a
  // random bit 7 so masking to seven bits is exercised.
  task automatic apply_setting(input logic [7:0] sf, input logic [7:0] ss,
                               input logic [7:0] ef, input logic [7:0] es,
                               input logic [7:0] fid, input logic [6:0] mn,
                               input logic [6:0] mx);
    in_valid_i <= 1'b0;
    // outstanding count is looked at mid-cycle, clear of the monitor's edge
    do @(negedge clk_i); while (tracker.outstanding() != 0);
    @(posedge clk_i);
    reg_val[REG_START_FIRST]  = sf;
    reg_val[REG_START_SECOND] = ss;
    reg_val[REG_END_FIRST]    = ef;
    reg_val[REG_END_SECOND]   = es;
    reg_val[REG_ACCEPT_ID]    = fid;
    reg_val[REG_MIN_LEN]      = {1'($urandom_range(1)), mn};
    reg_val[REG_MAX_LEN]      = {1'($urandom_range(1)), mx};
    write_reg(REG_START_FIRST,  reg_val[REG_START_FIRST]);
    write_reg(REG_START_SECOND, reg_val[REG_START_SECOND]);
    write_reg(REG_END_FIRST,    reg_val[REG_END_FIRST]);
    write_reg(REG_END_SECOND,   reg_val[REG_END_SECOND]);
    write_reg(REG_ACCEPT_ID,    reg_val[REG_ACCEPT_ID]);
    write_reg(REG_MIN_LEN,      reg_val[REG_MIN_LEN]);
    write_reg(REG_MAX_LEN,      reg_val[REG_MAX_LEN]);
    write_reg(RegSpare,         8'($urandom_range(255)));
    cfg_valid_i <= 1'b0;
  endtask

  // Build a frame from the current markers. cut > 0 sends only that many
  // leading bytes, leaving the receiver mid-frame. Payload of a length above
  // 72 is capped so rejected lengths stay cheap.
  task automatic send_frame(input logic [7:0] id, input logic [7:0] len,
                            input bit good_end, input bit twice_start,
                            input int cut);
    logic [7:0] seq[$];
    int         body;
    body = (len > 8'd72) ? 20 : int'(len);
    seq.push_back(reg_val[REG_START_FIRST]);
    if (twice_start) seq.push_back(reg_val[REG_START_FIRST]);
    seq.push_back(reg_val[REG_START_SECOND]);
    seq.push_back(id);
    seq.push_back(len);
    repeat (body + 2) seq.push_back(8'($urandom_range(255)));
    if (good_end || $urandom_range(1) == 0) begin
      seq.push_back(reg_val[REG_END_FIRST]);
      seq.push_back(good_end ? reg_val[REG_END_SECOND] : 8'($urandom_range(255)));
    end else begin
      seq.push_back(8'($urandom_range(255)));
      seq.push_back(reg_val[REG_END_SECOND]);
    end
    if (cut > 0 && cut < seq.size()) seq = seq[0:cut-1];
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Legal length for the current registers, mostly short; anything from 0 to 80
  // when the window is empty or now and then for a rejection.
  function automatic logic [7:0] pick_len();
    int lo, hi;
    lo = (int'(reg_val[REG_MIN_LEN][6:0]) + 3) / 4 * 4;
    hi = int'(reg_val[REG_MAX_LEN][6:0]);
    if (hi > int'(MaxPayload)) hi = int'(MaxPayload);
    hi = hi / 4 * 4;
    if (lo > hi || $urandom_range(9) == 0) return 8'($urandom_range(80));
    if (hi > lo + 16 && $urandom_range(4) != 0) hi = lo + 16;
    return 8'(lo + 4 * $urandom_range((hi - lo) / 4));
  endfunction

  // Mostly well-formed frames with random content; some noise, some frames
  // cut short, some with a foreign id or a broken trailer.
  task automatic run_random(input int unsigned budget);
    int unsigned first;
    int unsigned r;
    logic [7:0]  id;
    first = bytes_sent;
    while (bytes_sent - first < budget) begin
      r  = $urandom_range(99);
      id = ($urandom_range(99) < 85) ? reg_val[REG_ACCEPT_ID] : 8'($urandom_range(255));
      if (r < 8) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
      end else if (r < 14) begin
        send_frame(id, pick_len(), 1'b1, 1'b0, $urandom_range(1, 6));
      end else begin
        send_frame(id, pick_len(), $urandom_range(9) != 0, $urandom_range(9) == 0, 0);
      end
    end
  endtask

  initial begin : stimulus
    int          ph;
    logic [6:0]  mn;
    tracker = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extreme markers, max above the hard ceiling.
    apply_setting(8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 7'd0, 7'h7F);
    // repeated first start byte, then a zero-length frame that is accepted
    send_frame(8'hFF, 8'd0, 1'b1, 1'b1, 0);
    // length 68 passes the register but not the ceiling
    send_frame(8'hFF, 8'd68, 1'b1, 1'b0, 4);
    // wrong second start byte restarts
    send_byte(8'hFF);
    send_byte(8'h12);
    // short payload: only the x word gets data, the rest reads as zero
    send_frame(8'hFF, 8'd4, 1'b1, 1'b0, 0);
    // registers change mid-frame; the end-of-frame length check now fails
    send_frame(8'hFF, 8'd4, 1'b1, 1'b0, 5);
    apply_setting(8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 7'd0, 7'd0);
    repeat (5) send_byte(8'($urandom_range(255)));
    send_byte(reg_val[REG_END_FIRST]);
    send_byte(reg_val[REG_END_SECOND]);

    // Random phases, each under its own register setting.
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: apply_setting(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 7'd0, 7'd64);
        1: apply_setting(8'hFF, 8'hFF, 8'hFF, 8'hFF,
                         8'($urandom_range(255)), 7'd64, 7'd64);
        5: apply_setting(8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(255)), 7'd40, 7'd8);
        default: begin
          mn = 7'($urandom_range(24));
          apply_setting(8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), mn,
                        ($urandom_range(3) == 0) ? 7'h7F : 7'(mn + $urandom_range(40)));
        end
      endcase
      calm <= (ph == 3);
      run_random((ph == 1) ? 250 : 200);
    end

    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (tracker.outstanding() != 0);
    repeat (4) @(posedge clk_i);
    if (tracker.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
